### rtl/core/gda_pkg.sv
`default_nettype none

package gda_pkg;

	// Stream word widths
	localparam int IN_TDATA_W  = 72;
	localparam int IN_TUSER_W  = 2;
	localparam int OUT_TDATA_W = 56;

	// Input word field positions (lowest bit of each field)
	localparam int I_DAY_A   = 0;
	localparam int I_MONTH_A = 5;
	localparam int I_YEAR_A  = 9;
	localparam int I_DAY_B   = 23;
	localparam int I_MONTH_B = 28;
	localparam int I_YEAR_B  = 32;
	localparam int I_DELTA   = 46;

	// Output word field positions
	localparam int O_DAY   = 0;
	localparam int O_MONTH = 5;
	localparam int O_YEAR  = 9;
	localparam int O_DIFF  = 23;
	localparam int O_LT    = 46;
	localparam int O_GT    = 47;
	localparam int O_EQ    = 48;
	localparam int O_OOR   = 49;
	localparam int O_USED  = 50;

	// Operation codes carried on tuser
	localparam logic [1:0] FUNC_ADD  = 2'd0;
	localparam logic [1:0] FUNC_SUB  = 2'd1;
	localparam logic [1:0] FUNC_DIFF = 2'd2;
	localparam logic [1:0] FUNC_CMP  = 2'd3;

	// Year unit operand select
	localparam logic [1:0] YSEL_A    = 2'd0;
	localparam logic [1:0] YSEL_B    = 2'd1;
	localparam logic [1:0] YSEL_NEXT = 2'd2;
	localparam logic [1:0] YSEL_CUR  = 2'd3;

	// Reciprocals: ceil(2^24 / 100) and floor(2^24 * 400 / 146097)
	localparam int          RECIP_SHIFT = 24;
	localparam logic [17:0] RECIP_100   = 18'd167773;
	localparam logic [15:0] RECIP_YEAR  = 16'd45934;

	// Day number of 1 January, year 1, and difference saturation bound
	localparam int          FIRST_DAY  = 366;
	localparam logic [22:0] DIFF_LIMIT = 23'd3660000;

	// Controller to datapath commands
	typedef struct packed {
		logic       load;
		logic       yr_go;
		logic [1:0] yr_sel;
		logic       ser_a;
		logic       ser_b;
		logic       arith;
		logic       est;
		logic       yy_inc;
		logic       yy_dec;
		logic       rem_load;
		logic       mon_step;
		logic       date_fin;
		logic       pair_fin;
		logic       out_load;
	} gda_cmd_t;

	// Datapath to controller status
	typedef struct packed {
		logic [1:0] func;
		logic       inc_ok;
		logic       dec_more;
		logic       mon_more;
	} gda_sts_t;

	// Length of month m (1..12)
	function automatic logic [4:0] month_len(input logic [3:0] m, input logic leap);
		logic [4:0] len;
		case (m)
			4'd2: len = leap ? 5'd29 : 5'd28;
			4'd4, 4'd6, 4'd9, 4'd11: len = 5'd30;
			default: len = 5'd31;
		endcase
		return len;
	endfunction

	// Days in the year before the first of month m (1..12)
	function automatic logic [8:0] days_before_month(input logic [3:0] m, input logic leap);
		logic [8:0] base;
		case (m)
			4'd1: base = 9'd0;
			4'd2: base = 9'd31;
			4'd3: base = 9'd59;
			4'd4: base = 9'd90;
			4'd5: base = 9'd120;
			4'd6: base = 9'd151;
			4'd7: base = 9'd181;
			4'd8: base = 9'd212;
			4'd9: base = 9'd243;
			4'd10: base = 9'd273;
			4'd11: base = 9'd304;
			4'd12: base = 9'd334;
			default: base = 9'd0;
		endcase
		if (m > 4'd2 && leap) begin
			base = base + 9'd1;
		end
		return base;
	endfunction

endpackage

`default_nettype wire

### rtl/core/gda_year.sv
`default_nettype none

// Days before a given year, and its leap flag; two register stages.
module gda_year import gda_pkg::*; #(
	parameter int YUW = 14,
	parameter int BW  = 23
) (
	input  wire logic           clk,
	input  wire logic           go,
	input  wire logic [YUW-1:0] y,
	output logic      [BW-1:0]  by,
	output logic                leap
);

	localparam int QW = YUW - 6;
	localparam int PW = YUW + 18;

	logic [YUW-1:0] y_s1;
	logic [QW-1:0]  q_s1;
	logic [PW-1:0]  prod;
	logic [YUW:0]   hund;
	logic           century;
	logic [QW:0]    c100;
	logic [QW:0]    c400;
	logic [YUW-1:0] c4;
	logic [BW-1:0]  sum;
	logic [BW-1:0]  by_s2;
	logic           leap_s2;

	// Quotient by 100 through the reciprocal
	assign prod = PW'(y) * PW'(RECIP_100);

	always_ff @(posedge clk) begin
		if (go) begin
			y_s1 <= y;
			q_s1 <= prod[RECIP_SHIFT +: QW];
		end
	end

	// Ceilings by 4, 100, 400 and the leap rule
	always_comb begin
		hund    = (YUW+1)'(q_s1) * (YUW+1)'(100);
		century = (hund == {1'b0, y_s1});
		c100    = {1'b0, q_s1} + (QW+1)'(!century);
		c400    = (c100 + (QW+1)'(3)) >> 2;
		c4      = (YUW)'(({1'b0, y_s1} + (YUW+1)'(3)) >> 2);
		sum     = BW'(y_s1) * BW'(365) + BW'(c4) - BW'(c100) + BW'(c400);
	end

	always_ff @(posedge clk) begin
		by_s2   <= sum;
		leap_s2 <= (y_s1[1:0] == 2'b00) && (!century || q_s1[1:0] == 2'b00);
	end

	assign by   = by_s2;
	assign leap = leap_s2;

endmodule

`default_nettype wire

### rtl/core/gda_dp.sv
`default_nettype none

module gda_dp import gda_pkg::*; #(
	parameter int YEAR_MAX = 9999
) (
	input  wire logic                   clk,
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,
	input  wire logic [IN_TUSER_W-1:0]  s_tuser,
	input  wire gda_cmd_t               cmd,
	output gda_sts_t                    sts,
	output logic      [OUT_TDATA_W-1:0] m_tdata
);

	localparam int YUW = ($clog2(YEAR_MAX + 3) > 14) ? $clog2(YEAR_MAX + 3) : 14;
	localparam int BW  = YUW + 9;
	localparam int SW  = YUW + 11;
	localparam int UW  = SW - 1;
	localparam int EW  = UW + 16;
	localparam int HI  = 365 * (YEAR_MAX + 1) + (YEAR_MAX + 4) / 4
		- (YEAR_MAX + 100) / 100 + (YEAR_MAX + 400) / 400 - 1;

	localparam logic signed [SW-1:0] S_LO   = SW'(FIRST_DAY);
	localparam logic signed [SW-1:0] S_HI   = SW'(HI);
	localparam logic signed [SW-1:0] S_DMAX = SW'(DIFF_LIMIT);
	localparam logic signed [SW-1:0] S_DMIN = -S_DMAX;

	// Captured operands
	logic [1:0]  func_q;
	logic [4:0]  da_q, db_q;
	logic [3:0]  ma_q, mb_q;
	logic [13:0] ya_q, yb_q;
	logic [19:0] delta_q;

	// Working registers
	logic signed [SW-1:0] ser_a_q, ser_b_q, s_q;
	logic [22:0]          key_a_q, key_b_q;
	logic [YUW-1:0]       yy_q;
	logic [8:0]           r_q;
	logic [3:0]           mm_q;
	logic                 leap_q;

	// Result and output registers
	logic [4:0]             rd_q;
	logic [3:0]             rm_q;
	logic [13:0]            ry_q;
	logic [22:0]            diff_q;
	logic                   lt_q, gt_q, eq_q, oor_q;
	logic [OUT_TDATA_W-1:0] out_q;

	// Year unit
	logic [YUW-1:0] yr_y;
	logic [BW-1:0]  yr_by;
	logic           yr_leap;

	logic [3:0]           sel_m;
	logic [4:0]           sel_d;
	logic [13:0]          sel_y;
	logic [8:0]           doy;
	logic signed [SW-1:0] ser_new;
	logic signed [SW-1:0] dext;
	logic signed [SW-1:0] sum;
	logic signed [SW-1:0] diff_v;
	logic [UW-1:0]        s_u;
	logic [UW-1:0]        by_ext;
	logic [UW-1:0]        rem;
	logic [EW-1:0]        est_prod;
	logic [4:0]           mlen;

	function automatic logic [3:0] clamp_month(input logic [3:0] m);
		logic [3:0] c;
		if (m == 4'd0) begin
			c = 4'd1;
		end else if (m > 4'd12) begin
			c = 4'd12;
		end else begin
			c = m;
		end
		return c;
	endfunction

	// Pick the year for the shared year unit
	always_comb begin
		case (cmd.yr_sel)
			YSEL_A: yr_y = YUW'(ya_q);
			YSEL_B: yr_y = YUW'(yb_q);
			YSEL_NEXT: yr_y = yy_q + YUW'(1);
			YSEL_CUR: yr_y = yy_q;
			default: yr_y = yy_q;
		endcase
	end

	gda_year #(
		.YUW (YUW),
		.BW  (BW)
	) u_year (
		.clk  (clk),
		.go   (cmd.yr_go),
		.y    (yr_y),
		.by   (yr_by),
		.leap (yr_leap)
	);

	// Day number and ordering key of the date being converted
	always_comb begin
		sel_m   = cmd.ser_b ? mb_q : ma_q;
		sel_d   = cmd.ser_b ? db_q : da_q;
		sel_y   = cmd.ser_b ? yb_q : ya_q;
		doy     = days_before_month(sel_m, yr_leap) + 9'(sel_d);
		ser_new = $signed(SW'(yr_by)) + $signed(SW'(doy)) - $signed(SW'(1));
	end

	// Offset, difference, year estimate and month walk terms
	always_comb begin
		dext     = $signed(SW'(delta_q));
		sum      = (func_q == FUNC_SUB) ? (ser_a_q - dext) : (ser_a_q + dext);
		diff_v   = ser_a_q - ser_b_q;
		s_u      = s_q[UW-1:0];
		by_ext   = UW'(yr_by);
		rem      = s_u - by_ext;
		est_prod = EW'(s_u) * EW'(RECIP_YEAR);
		mlen     = month_len(mm_q, leap_q);
	end

	assign sts.func     = func_q;
	assign sts.inc_ok   = (by_ext <= s_u);
	assign sts.dec_more = (by_ext > s_u) && (yy_q != '0);
	assign sts.mon_more = (mm_q < 4'd12) && (r_q >= 9'(mlen));

	always_ff @(posedge clk) begin
		// Capture a new word and clear the result
		if (cmd.load) begin
			func_q  <= s_tuser;
			da_q    <= s_tdata[I_DAY_A +: 5];
			ma_q    <= clamp_month(s_tdata[I_MONTH_A +: 4]);
			ya_q    <= s_tdata[I_YEAR_A +: 14];
			db_q    <= s_tdata[I_DAY_B +: 5];
			mb_q    <= clamp_month(s_tdata[I_MONTH_B +: 4]);
			yb_q    <= s_tdata[I_YEAR_B +: 14];
			delta_q <= s_tdata[I_DELTA +: 20];
			rd_q    <= '0;
			rm_q    <= '0;
			ry_q    <= '0;
			diff_q  <= '0;
			lt_q    <= 1'b0;
			gt_q    <= 1'b0;
			eq_q    <= 1'b0;
			oor_q   <= 1'b0;
		end

		if (cmd.ser_a) begin
			ser_a_q <= ser_new;
			key_a_q <= {sel_y, doy};
		end
		if (cmd.ser_b) begin
			ser_b_q <= ser_new;
			key_b_q <= {sel_y, doy};
		end

		// Offset the day number and saturate to the supported years
		if (cmd.arith) begin
			if (sum < S_LO) begin
				s_q   <= S_LO;
				oor_q <= 1'b1;
			end else if (sum > S_HI) begin
				s_q   <= S_HI;
				oor_q <= 1'b1;
			end else begin
				s_q <= sum;
			end
		end

		// Year estimate, then step it to the exact year
		if (cmd.est) begin
			yy_q <= est_prod[RECIP_SHIFT +: YUW];
		end else if (cmd.yy_inc) begin
			yy_q <= yy_q + YUW'(1);
		end else if (cmd.yy_dec) begin
			yy_q <= yy_q - YUW'(1);
		end

		// Walk months over the day of year
		if (cmd.rem_load) begin
			r_q    <= rem[8:0];
			leap_q <= yr_leap;
			mm_q   <= 4'd1;
		end else if (cmd.mon_step) begin
			r_q  <= r_q - 9'(mlen);
			mm_q <= mm_q + 4'd1;
		end

		if (cmd.date_fin) begin
			rd_q <= r_q[4:0] + 5'd1;
			rm_q <= mm_q;
			ry_q <= yy_q[13:0];
		end

		// Difference with saturation, or ordering
		if (cmd.pair_fin) begin
			if (func_q == FUNC_DIFF) begin
				if (diff_v > S_DMAX) begin
					diff_q <= DIFF_LIMIT;
					oor_q  <= 1'b1;
				end else if (diff_v < S_DMIN) begin
					diff_q <= S_DMIN[22:0];
					oor_q  <= 1'b1;
				end else begin
					diff_q <= diff_v[22:0];
				end
			end else begin
				lt_q <= (key_a_q < key_b_q);
				gt_q <= (key_a_q > key_b_q);
				eq_q <= (key_a_q == key_b_q);
			end
		end

		if (cmd.out_load) begin
			out_q <= {(OUT_TDATA_W - O_USED)'(0), oor_q, eq_q, gt_q, lt_q, diff_q,
				ry_q, rm_q, rd_q};
		end
	end

	assign m_tdata = out_q;

endmodule

`default_nettype wire

### rtl/core/gda_ctrl.sv
`default_nettype none

module gda_ctrl import gda_pkg::*; (
	input  wire logic     clk,
	input  wire logic     arst_n,
	input  wire logic     s_tvalid,
	output logic          s_tready,
	output logic          m_tvalid,
	input  wire logic     m_tready,
	input  wire gda_sts_t sts,
	output gda_cmd_t      cmd
);

	localparam logic [4:0] ST_IDLE    = 5'd0;
	localparam logic [4:0] ST_YA      = 5'd1;
	localparam logic [4:0] ST_YA_W    = 5'd2;
	localparam logic [4:0] ST_SA      = 5'd3;
	localparam logic [4:0] ST_YB      = 5'd4;
	localparam logic [4:0] ST_YB_W    = 5'd5;
	localparam logic [4:0] ST_SB      = 5'd6;
	localparam logic [4:0] ST_PAIR    = 5'd7;
	localparam logic [4:0] ST_ARITH   = 5'd8;
	localparam logic [4:0] ST_EST     = 5'd9;
	localparam logic [4:0] ST_INC     = 5'd10;
	localparam logic [4:0] ST_INC_W   = 5'd11;
	localparam logic [4:0] ST_INC_CHK = 5'd12;
	localparam logic [4:0] ST_DEC     = 5'd13;
	localparam logic [4:0] ST_DEC_W   = 5'd14;
	localparam logic [4:0] ST_DEC_CHK = 5'd15;
	localparam logic [4:0] ST_MON     = 5'd16;
	localparam logic [4:0] ST_DONE    = 5'd17;

	logic [4:0] state_q, state_d;
	logic       out_valid_q;
	logic       out_free;

	assign out_free = !out_valid_q || m_tready;
	assign s_tready = (state_q == ST_IDLE);
	assign m_tvalid = out_valid_q;

	// Sequence one word through the datapath
	always_comb begin
		state_d = state_q;
		cmd     = '0;
		case (state_q)
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.load = 1'b1;
					state_d  = ST_YA;
				end
			end
			ST_YA: begin
				cmd.yr_go  = 1'b1;
				cmd.yr_sel = YSEL_A;
				state_d    = ST_YA_W;
			end
			ST_YA_W: state_d = ST_SA;
			ST_SA: begin
				cmd.ser_a = 1'b1;
				if (sts.func == FUNC_ADD || sts.func == FUNC_SUB) begin
					state_d = ST_ARITH;
				end else begin
					state_d = ST_YB;
				end
			end
			ST_YB: begin
				cmd.yr_go  = 1'b1;
				cmd.yr_sel = YSEL_B;
				state_d    = ST_YB_W;
			end
			ST_YB_W: state_d = ST_SB;
			ST_SB: begin
				cmd.ser_b = 1'b1;
				state_d   = ST_PAIR;
			end
			ST_PAIR: begin
				cmd.pair_fin = 1'b1;
				state_d      = ST_DONE;
			end
			ST_ARITH: begin
				cmd.arith = 1'b1;
				state_d   = ST_EST;
			end
			ST_EST: begin
				cmd.est = 1'b1;
				state_d = ST_INC;
			end
			ST_INC: begin
				cmd.yr_go  = 1'b1;
				cmd.yr_sel = YSEL_NEXT;
				state_d    = ST_INC_W;
			end
			ST_INC_W: state_d = ST_INC_CHK;
			ST_INC_CHK: begin
				if (sts.inc_ok) begin
					cmd.yy_inc = 1'b1;
					state_d    = ST_INC;
				end else begin
					state_d = ST_DEC;
				end
			end
			ST_DEC: begin
				cmd.yr_go  = 1'b1;
				cmd.yr_sel = YSEL_CUR;
				state_d    = ST_DEC_W;
			end
			ST_DEC_W: state_d = ST_DEC_CHK;
			ST_DEC_CHK: begin
				if (sts.dec_more) begin
					cmd.yy_dec = 1'b1;
					state_d    = ST_DEC;
				end else begin
					cmd.rem_load = 1'b1;
					state_d      = ST_MON;
				end
			end
			ST_MON: begin
				if (sts.mon_more) begin
					cmd.mon_step = 1'b1;
				end else begin
					cmd.date_fin = 1'b1;
					state_d      = ST_DONE;
				end
			end
			ST_DONE: begin
				if (out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			// Hold the result word until taken
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

### rtl/core/gregorian_date_arithmetic.sv
`default_nettype none

// Channel  Dir  Signals                     Contents
// s_*      in   tvalid tready tdata tuser   date A, date B, day count; tuser op code
// m_*      out  tvalid tready tdata         result date, difference, ordering, range flag
//
// One word is in work at a time. Difference and compare run one pass of the year unit
// per date. Add and subtract make three or more passes of the shared two-stage year
// unit (date A, then the increment and decrement checks), plus one step per month walked.
// The next word is taken the cycle after the result loads; a result still waiting
// on m_tready holds the controller before that load. Reset clears the controller
// and empties the output.
module gregorian_date_arithmetic import gda_pkg::*; #(
	parameter int YEAR_MAX = 9999
) (
	input  wire logic                   clk,
	input  wire logic                   arst_n,
	input  wire logic                   s_tvalid,
	output logic                        s_tready,
	// day_a[4:0] month_a[8:5] year_a[22:9] day_b[27:23] month_b[31:28]
	// year_b[45:32] delta[65:46], zero fill above
	input  wire logic [IN_TDATA_W-1:0]  s_tdata,
	// func[1:0]
	input  wire logic [IN_TUSER_W-1:0]  s_tuser,
	output logic                        m_tvalid,
	input  wire logic                   m_tready,
	// res_day[4:0] res_month[8:5] res_year[22:9] day_difference[45:23]
	// a_less[46] a_greater[47] a_equal[48] out_of_range[49], zero fill above
	output logic      [OUT_TDATA_W-1:0] m_tdata
);

	gda_cmd_t cmd;
	gda_sts_t sts;

	gda_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	gda_dp #(
		.YEAR_MAX (YEAR_MAX)
	) u_dp (
		.clk     (clk),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.cmd     (cmd),
		.sts     (sts),
		.m_tdata (m_tdata)
	);

`ifndef SYNTHESIS
	// An accepted word keeps the block busy for the next cycle
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input taken again right after accept");

	// Never overwrite a result that has not been taken
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!m_tvalid || m_tready))
		else $error("result overwritten while stalled");

	// Output valid only rises after a result load
	a_valid_from_load: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_tvalid) |-> $past(cmd.out_load))
		else $error("output valid without a result load");

	// At most one ordering flag is set
	a_order_onehot: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid |-> $onehot0(m_tdata[O_LT +: 3]))
		else $error("conflicting ordering flags");
`endif

endmodule

`default_nettype wire
